/* sv/hrf_pkg.sv */
// ----------------------------------------------------------------------------
// hrf_pkg: shared types and helpers for the HTTP request header framer
// Byte classes, parse phase codes, verdict codes and the request-line matcher.
// ----------------------------------------------------------------------------
package hrf_pkg;

    // Character codes
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Parse phases of the request line
    localparam logic [3:0] PH_G        = 4'd0;
    localparam logic [3:0] PH_E        = 4'd1;
    localparam logic [3:0] PH_T        = 4'd2;
    localparam logic [3:0] PH_PATH_WS  = 4'd3;
    localparam logic [3:0] PH_PATH     = 4'd4;
    localparam logic [3:0] PH_H        = 4'd5;
    localparam logic [3:0] PH_T1       = 4'd6;
    localparam logic [3:0] PH_T2       = 4'd7;
    localparam logic [3:0] PH_P        = 4'd8;
    localparam logic [3:0] PH_SLASH    = 4'd9;
    localparam logic [3:0] PH_VER_WS   = 4'd10;
    localparam logic [3:0] PH_VER      = 4'd11;
    localparam logic [3:0] PH_FAIL     = 4'd12;
    localparam logic [3:0] PH_VER_DONE = 4'd13;

    // Verdict codes
    localparam logic [2:0] VERDICT_NONE        = 3'd0;
    localparam logic [2:0] VERDICT_SERVE       = 3'd1;
    localparam logic [2:0] VERDICT_BAD_REQUEST = 3'd2;
    localparam logic [2:0] VERDICT_TOO_LARGE   = 3'd3;
    localparam logic [2:0] VERDICT_BAD_VERSION = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 1'd1;

    localparam logic [7:0]  LINE_LIMIT_RESET = 8'd32;
    localparam logic [15:0] BYTE_LIMIT_RESET = 16'd4096;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Classification of one byte
    typedef struct packed {
        logic is_ws;
        logic is_zero;
        logic is_cr;
        logic is_lf;
        logic is_g;
        logic is_e;
        logic is_t;
        logic is_h;
        logic is_p;
        logic is_slash;
        logic is_one;
        logic is_dot;
    } hrf_class_t;

    // Classified item carried through the queue
    typedef struct packed {
        logic       first;
        hrf_class_t cls;
    } hrf_entry_t;

    // Limits from the configuration registers
    typedef struct packed {
        logic [7:0]  line_limit;
        logic [15:0] byte_limit;
    } hrf_cfg_t;

    // Request-line matcher state
    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] vchars;
        logic       vmatch;
        logic       slash;
        logic       text_ended;
    } hrf_parse_t;

    typedef struct packed {
        hrf_parse_t st;
        logic       path;
    } hrf_feed_t;

    function automatic hrf_class_t hrf_classify(input logic [7:0] c);
        hrf_class_t r;
        r.is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
        r.is_zero  = (c == 8'h00);
        r.is_cr    = (c == CHAR_CR);
        r.is_lf    = (c == CHAR_LF);
        r.is_g     = (c == CHAR_G);
        r.is_e     = (c == CHAR_E);
        r.is_t     = (c == CHAR_T);
        r.is_h     = (c == CHAR_H);
        r.is_p     = (c == CHAR_P);
        r.is_slash = (c == CHAR_SLASH);
        r.is_one   = (c == CHAR_ONE);
        r.is_dot   = (c == CHAR_DOT);
        return r;
    endfunction

    // One text byte of the request line against "GET %s HTTP/%3s"
    function automatic hrf_feed_t hrf_feed(input hrf_parse_t st, input logic lines_zero,
                                           input hrf_class_t c);
        hrf_feed_t r;
        logic [1:0] vc;
        r.st   = st;
        r.path = 1'b0;
        vc     = st.vchars + 2'd1;
        if (!st.text_ended && lines_zero) begin
            if (c.is_zero) begin
                r.st.text_ended = 1'b1;
            end else begin
                unique case (st.phase)
                    PH_G:     r.st.phase = c.is_g ? PH_E : PH_FAIL;
                    PH_E:     r.st.phase = c.is_e ? PH_T : PH_FAIL;
                    PH_T:     r.st.phase = c.is_t ? PH_PATH_WS : PH_FAIL;
                    PH_PATH_WS, PH_PATH: begin
                        if (c.is_ws) begin
                            if (st.phase == PH_PATH) r.st.phase = PH_H;
                        end else begin
                            r.st.phase = PH_PATH;
                            r.st.slash = c.is_slash;
                            r.path     = 1'b1;
                        end
                    end
                    PH_H: begin
                        if (!c.is_ws) r.st.phase = c.is_h ? PH_T1 : PH_FAIL;
                    end
                    PH_T1:    r.st.phase = c.is_t ? PH_T2 : PH_FAIL;
                    PH_T2:    r.st.phase = c.is_t ? PH_P : PH_FAIL;
                    PH_P:     r.st.phase = c.is_p ? PH_SLASH : PH_FAIL;
                    PH_SLASH: r.st.phase = c.is_slash ? PH_VER_WS : PH_FAIL;
                    PH_VER_WS: begin
                        if (!c.is_ws) begin
                            r.st.vchars = 2'd1;
                            r.st.vmatch = c.is_one;
                            r.st.phase  = PH_VER;
                        end
                    end
                    PH_VER: begin
                        if (c.is_ws) begin
                            r.st.phase = PH_VER_DONE;
                        end else begin
                            if (!((st.vchars == 2'd1) ? c.is_dot : c.is_one))
                                r.st.vmatch = 1'b0;
                            r.st.vchars = vc;
                            if (vc == 2'd3) r.st.phase = PH_VER_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    // Verdict given by the empty line
    function automatic logic [2:0] hrf_header_verdict(input hrf_parse_t st);
        logic [2:0] v;
        if ((st.phase == PH_VER) || (st.phase == PH_VER_DONE))
            v = ((st.vchars == 2'd3) && st.vmatch) ? VERDICT_SERVE : VERDICT_BAD_VERSION;
        else
            v = VERDICT_BAD_REQUEST;
        return v;
    endfunction

endpackage

/* sv/hrf_front.sv */
// ----------------------------------------------------------------------------
// hrf_front: input side of the framer
// Accepts request bytes while the queue has room and classifies each byte.
// ----------------------------------------------------------------------------
module hrf_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               fifo_full,
    output logic               push,
    output hrf_pkg::hrf_entry_t push_entry
);
    import hrf_pkg::*;

    // Take items whenever the queue has a free slot
    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    // Byte class and new-connection flag
    always_comb begin
        push_entry.first = s_tuser;
        push_entry.cls   = hrf_classify(s_tdata);
    end

endmodule

/* sv/hrf_fifo.sv */
// ----------------------------------------------------------------------------
// hrf_fifo: short queue of classified items
// Register-based FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module hrf_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hrf_pkg::hrf_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output hrf_pkg::hrf_entry_t head_entry
);
    import hrf_pkg::*;

    hrf_entry_t            slots_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)      count_next = count_reg + FIFO_CNT_W'(1);
        else if (!push && pop) count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge aclk) begin
        if (push) slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* sv/hrf_back.sv */
// ----------------------------------------------------------------------------
// hrf_back: line framing, request-line matching and verdict
// Pops one classified item per cycle while the output register is free or being
// drained, updates the header state and registers one result item.
// ----------------------------------------------------------------------------
module hrf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  hrf_pkg::hrf_cfg_t   cfg,
    input  logic                head_valid,
    input  hrf_pkg::hrf_entry_t head_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast
);
    import hrf_pkg::*;

    typedef struct packed {
        logic        cr_held;
        logic [15:0] bytes_seen;
        logic [7:0]  lines_seen;
        logic        line_nonempty;
        hrf_parse_t  parse;
        logic        finished;
    } hrf_hdr_t;

    localparam hrf_hdr_t HDR_CLEAR = '{
        cr_held:       1'b0,
        bytes_seen:    16'd0,
        lines_seen:    8'd0,
        line_nonempty: 1'b0,
        parse:         '{phase: PH_G, vchars: 2'd0, vmatch: 1'b1, slash: 1'b0,
                         text_ended: 1'b0},
        finished:      1'b0
    };

    hrf_hdr_t   hdr_reg, hdr_next;
    hrf_hdr_t   cur;
    hrf_feed_t  feed_cr, feed_byte;
    hrf_parse_t parse_mid;
    logic       lines_zero;

    logic [2:0] verdict;
    logic       path;
    logic       done_line;
    logic       wants_index;

    logic       out_valid_reg;
    logic [2:0] out_verdict_reg;
    logic       out_path_reg;
    logic       out_index_reg;
    logic       out_last_reg;
    logic [7:0] out_line_idx_reg;

    // Pop when the output register is free or being drained
    assign pop = head_valid && (!out_valid_reg || m_tready);

    // A new connection starts from cleared state
    assign cur = head_entry.first ? HDR_CLEAR : hdr_reg;

    // Held CR and current byte go through the matcher in order
    assign lines_zero = (cur.lines_seen == 8'd0);
    assign feed_cr    = hrf_feed(cur.parse, lines_zero, hrf_classify(CHAR_CR));
    assign parse_mid  = cur.cr_held ? feed_cr.st : cur.parse;
    assign feed_byte  = hrf_feed(parse_mid, lines_zero, head_entry.cls);

    // Header state update for one item
    always_comb begin
        hdr_next  = cur;
        verdict   = VERDICT_NONE;
        path      = 1'b0;
        done_line = 1'b0;
        if (!cur.finished) begin
            if (cur.bytes_seen != 16'hFFFF) hdr_next.bytes_seen = cur.bytes_seen + 16'd1;
            if (cur.cr_held && head_entry.cls.is_lf) begin
                done_line              = 1'b1;
                hdr_next.cr_held       = 1'b0;
                hdr_next.line_nonempty = 1'b0;
                if (lines_zero) hdr_next.parse.text_ended = 1'b1;
                if (cur.lines_seen != 8'hFF) hdr_next.lines_seen = cur.lines_seen + 8'd1;
                if (!cur.line_nonempty) begin
                    hdr_next.finished = 1'b1;
                    verdict           = hrf_header_verdict(cur.parse);
                end else if (hdr_next.lines_seen >= cfg.line_limit) begin
                    hdr_next.finished = 1'b1;
                    verdict           = VERDICT_TOO_LARGE;
                end
            end else begin
                if (cur.cr_held) hdr_next.line_nonempty = 1'b1;
                if (head_entry.cls.is_cr) begin
                    hdr_next.cr_held = 1'b1;
                    hdr_next.parse   = parse_mid;
                end else begin
                    hdr_next.cr_held       = 1'b0;
                    hdr_next.line_nonempty = 1'b1;
                    hdr_next.parse         = feed_byte.st;
                    path                   = feed_byte.path;
                end
            end
            if (!hdr_next.finished && (hdr_next.bytes_seen >= cfg.byte_limit)) begin
                hdr_next.finished = 1'b1;
                verdict           = VERDICT_TOO_LARGE;
            end
        end
        wants_index = (verdict == VERDICT_SERVE) && hdr_next.parse.slash;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= HDR_CLEAR;
        end else if (pop) begin
            hdr_reg <= hdr_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_verdict_reg  <= verdict;
            out_path_reg     <= path;
            out_index_reg    <= wants_index;
            out_last_reg     <= done_line;
            out_line_idx_reg <= hdr_next.lines_seen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_line_idx_reg, out_index_reg, out_path_reg,
                       out_verdict_reg};

endmodule

/* sv/http_request_header_framer.sv */
// ----------------------------------------------------------------------------
// http_request_header_framer: HTTP/1.1 request header framer
// Frames CRLF header lines, matches the request line and gives a verdict.
// ----------------------------------------------------------------------------
// One request byte enters per cycle while the queue has room and gives exactly
// one result item; the byte is queued and its result held in an output register.
// The front classifies each byte and writes it into a four-entry queue; the
// back pops one entry per cycle while its output register is free or draining,
// updates the line and parse state and loads that register, so the sustained
// rate is one byte per cycle whenever the result side keeps up. Set s_tuser on
// the first byte of each new connection. Limits must be written through the
// cfg port only while no bytes are in flight; the block does not enforce it.
module http_request_header_framer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request bytes
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tuser,   // [0] first_of_request
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [2:0] verdict, [3] is_path_byte,
                                                   // [4] wants_index, [12:5] line_index
    output logic                        m_tlast,   // line_complete
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                 cfg_data
);
    import hrf_pkg::*;

    logic       push;
    hrf_entry_t push_entry;
    logic       fifo_full;
    logic       pop;
    logic       head_valid;
    hrf_entry_t head_entry;

    logic [7:0]  line_limit_reg;
    logic [15:0] byte_limit_reg;
    hrf_cfg_t    cfg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_limit_reg <= LINE_LIMIT_RESET;
            byte_limit_reg <= BYTE_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LINE_LIMIT: line_limit_reg <= cfg_data[7:0];
                REG_BYTE_LIMIT: byte_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.line_limit = line_limit_reg;
    assign cfg.byte_limit = byte_limit_reg;

    hrf_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    hrf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    hrf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef ASSERT_OFF
    // A completed line always leaves a nonzero line count
    a_line_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[12:5] != 8'd0))
        else $error("line completed with zero line index");

    // Index flag only comes with a serve verdict
    a_wants_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> (m_tdata[2:0] == VERDICT_SERVE))
        else $error("wants_index without serve verdict");

    // The queue only pops what it holds
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

/* tb/sv/http_request_header_framer_test.sv */
// ----------------------------------------------------------------------------
// http_request_header_framer_test: self-checking bench for the header framer
// Streams request bytes under several limit settings, predicts every result
// item in step with the bytes accepted, and compares each result field.
// ----------------------------------------------------------------------------
module http_request_header_framer_test;
    import hrf_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;

    // Kinds of queued stimulus actions
    typedef enum logic [1:0] {
        ACT_BYTE,
        ACT_DRAIN,
        ACT_WRITE
    } action_e;

    typedef struct {
        action_e              act;
        logic [7:0]           data;
        logic                 first;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          value;
    } stim_t;

    // One result item as the framer reports it
    typedef struct packed {
        logic [2:0] verdict;
        logic       path;
        logic       index_wanted;
        logic       line_done;
        logic [7:0] line_count;
    } framer_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;   // [7:0] data_byte
    logic                 s_tuser   = 1'b0;    // [0] first_of_request
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;             // [2:0] verdict, [3] is_path_byte,
                                               // [4] wants_index, [12:5] line_index
    logic                 m_tlast;             // line_complete
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = 16'h0000;

    stim_t          pending[$];
    framer_result_t expected_q[$];

    int errors        = 0;
    int bytes_planned = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int writes_done   = 0;
    int verdict_count[5];
    logic s_took   = 1'b0;
    logic cfg_took = 1'b0;

    // Predictor state: limits and line / request-line parse state
    logic [7:0]  max_lines   = LINE_LIMIT_RESET;
    logic [15:0] max_bytes   = BYTE_LIMIT_RESET;
    logic        cr_pending  = 1'b0;
    logic [15:0] byte_total  = '0;
    logic [7:0]  lines_done  = '0;
    logic        line_started = 1'b0;
    logic [3:0]  phase       = PH_G;
    logic [1:0]  ver_len     = '0;
    logic        ver_good    = 1'b1;
    logic        path_slash  = 1'b0;
    logic        text_stop   = 1'b0;
    logic        header_closed = 1'b0;

    http_request_header_framer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // One text byte of the request line against "GET <path> HTTP/<ver>"
    task automatic match_request_text(input logic [7:0] c, output logic path_byte);
        logic ws;
        ws = is_space(c);
        path_byte = 1'b0;
        if (text_stop || lines_done != 8'd0) return;
        if (c == 8'h00) begin
            text_stop = 1'b1;
            return;
        end
        case (phase)
            PH_G:  phase = (c == CHAR_G) ? PH_E : PH_FAIL;
            PH_E:  phase = (c == CHAR_E) ? PH_T : PH_FAIL;
            PH_T:  phase = (c == CHAR_T) ? PH_PATH_WS : PH_FAIL;
            PH_PATH_WS, PH_PATH: begin
                if (ws) begin
                    if (phase == PH_PATH) phase = PH_H;
                end else begin
                    phase = PH_PATH;
                    path_slash = (c == CHAR_SLASH);
                    path_byte = 1'b1;
                end
            end
            PH_H: begin
                if (!ws) phase = (c == CHAR_H) ? PH_T1 : PH_FAIL;
            end
            PH_T1:    phase = (c == CHAR_T) ? PH_T2 : PH_FAIL;
            PH_T2:    phase = (c == CHAR_T) ? PH_P : PH_FAIL;
            PH_P:     phase = (c == CHAR_P) ? PH_SLASH : PH_FAIL;
            PH_SLASH: phase = (c == CHAR_SLASH) ? PH_VER_WS : PH_FAIL;
            PH_VER_WS: begin
                if (!ws) begin
                    ver_len = 2'd1;
                    ver_good = (c == CHAR_ONE);
                    phase = PH_VER;
                end
            end
            PH_VER: begin
                if (ws) begin
                    phase = PH_VER_DONE;
                end else begin
                    if (c != ((ver_len == 2'd1) ? CHAR_DOT : CHAR_ONE)) ver_good = 1'b0;
                    ver_len = ver_len + 2'd1;
                    if (ver_len == 2'd3) phase = PH_VER_DONE;
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [2:0] verdict_at_empty_line();
        if (phase == PH_VER || phase == PH_VER_DONE)
            return (ver_len == 2'd3 && ver_good) ? VERDICT_SERVE : VERDICT_BAD_VERSION;
        return VERDICT_BAD_REQUEST;
    endfunction

    task automatic frame_byte(input logic [7:0] b, input logic first,
                              output framer_result_t r);
        logic was_empty;
        logic dummy;
        r = '0;
        if (first) begin
            cr_pending = 1'b0; byte_total = '0; lines_done = '0; line_started = 1'b0;
            phase = PH_G; ver_len = '0; ver_good = 1'b1; path_slash = 1'b0;
            text_stop = 1'b0; header_closed = 1'b0;
        end
        if (header_closed) begin
            r.line_count = lines_done;
            return;
        end
        if (byte_total != 16'hFFFF) byte_total = byte_total + 16'd1;

        if (cr_pending && b == CHAR_LF) begin
            // CRLF closes a line; an empty one closes the header
            was_empty = !line_started;
            r.line_done = 1'b1;
            cr_pending = 1'b0;
            line_started = 1'b0;
            if (lines_done == 8'd0) text_stop = 1'b1;
            if (lines_done != 8'hFF) lines_done = lines_done + 8'd1;
            if (was_empty) begin
                header_closed = 1'b1;
                r.verdict = verdict_at_empty_line();
            end else if (lines_done >= max_lines) begin
                header_closed = 1'b1;
                r.verdict = VERDICT_TOO_LARGE;
            end
        end else begin
            // a held CR not followed by LF is plain line text
            if (cr_pending) begin
                line_started = 1'b1;
                match_request_text(CHAR_CR, dummy);
            end
            if (b == CHAR_CR) begin
                cr_pending = 1'b1;
            end else begin
                cr_pending = 1'b0;
                line_started = 1'b1;
                match_request_text(b, r.path);
            end
        end
        if (!header_closed && byte_total >= max_bytes) begin
            header_closed = 1'b1;
            r.verdict = VERDICT_TOO_LARGE;
        end
        r.index_wanted = (r.verdict == VERDICT_SERVE) && path_slash;
        r.line_count = lines_done;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic first);
        stim_t s;
        s.act = ACT_BYTE; s.data = b; s.first = first; s.idx = '0; s.value = '0;
        pending.push_back(s);
        bytes_planned++;
    endtask

    // literal text; the byte at bad_pos (if any) is replaced by a random one
    task automatic push_text(input string txt, input int bad_pos);
        for (int i = 0; i < txt.len(); i++)
            push_byte((i == bad_pos) ? 8'($urandom_range(255)) : 8'(txt[i]), 1'b0);
    endtask

    task automatic push_space(input int n);
        logic [7:0] ws_set[5];
        ws_set = '{CHAR_SPACE, CHAR_TAB, 8'h0B, 8'h0C, CHAR_SPACE};
        repeat (n) push_byte(ws_set[$urandom_range(4)], 1'b0);
    endtask

    task automatic push_pause();
        stim_t s;
        s.act = ACT_DRAIN; s.data = '0; s.first = 1'b0; s.idx = '0; s.value = '0;
        pending.push_back(s);
    endtask

    // wait for the block to go idle, then write both limits
    task automatic add_setting(input logic [15:0] lines, input logic [15:0] bytes);
        stim_t s;
        push_pause();
        s.act = ACT_WRITE; s.data = '0; s.first = 1'b0;
        s.idx = REG_LINE_LIMIT; s.value = lines;
        pending.push_back(s);
        s.idx = REG_BYTE_LIMIT; s.value = bytes;
        pending.push_back(s);
    endtask

    // one request: mostly well formed, with a random flaw now and then
    task automatic add_request();
        int flavor;
        int start;
        int n;
        int kind;
        flavor = $urandom_range(0, 19);
        start = pending.size();
        if (flavor == 7) begin
            // noise with random first marks
            repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(255)), 1'($urandom));
            return;
        end
        push_text("GET", (flavor == 0) ? int'($urandom_range(2)) : -1);
        push_space($urandom_range(0, 2));
        push_byte(CHAR_SLASH, 1'b0);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            push_byte((flavor == 1 && i == 0) ? 8'h00 : 8'($urandom_range(8'h21, 8'h7E)), 1'b0);
        if ($urandom_range(3) == 0) push_byte(CHAR_SLASH, 1'b0);
        push_space($urandom_range(0, 2) + ((flavor == 9) ? 0 : 1));
        push_text("HTTP/", (flavor == 8) ? int'($urandom_range(4)) : -1);
        push_space($urandom_range(0, 1));
        kind = $urandom_range(0, 17);
        case (kind)
            12: push_text("1.0", -1);
            13: push_text("2", -1);
            14: push_text("1.1x", -1);
            15: push_text("11.1", -1);
            16: ;
            17: push_text("1.1 junk", -1);
            default: push_text("1.1", -1);
        endcase
        if (flavor == 2) push_text("\r ", -1);
        push_text("\r\n", -1);
        // header fields
        n = (flavor == 4) ? int'($urandom_range(5, 10)) : int'($urandom_range(0, 3));
        for (int l = 0; l < n; l++) begin
            repeat ($urandom_range(1, 10))
                push_byte((flavor == 5) ? 8'($urandom_range(255))
                                        : 8'($urandom_range(8'h20, 8'h7E)), 1'b0);
            if (flavor == 3) push_byte(CHAR_LF, 1'b0);
            if (flavor == 2) push_byte(CHAR_CR, 1'b0);
            push_text("\r\n", -1);
        end
        if (flavor != 6) push_text("\r\n", -1);
        // bytes after the header are ignored
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(255)), 1'b0);
        pending[start].first = 1'b1;
    endtask

    task automatic add_traffic(input int count);
        int target;
        target = bytes_planned + count;
        while (bytes_planned < target) begin
            add_request();
            if ($urandom_range(7) == 0) push_pause();
        end
    endtask

    function automatic int idle_percent(input logic sender);
        int third;
        third = (bytes_planned == 0) ? 0 : (bytes_sent * 3) / bytes_planned;
        if (third == 0) return sender ? 22 : 62;
        if (third == 1) return sender ? 62 : 22;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        $display("[%0t] mismatch on result %0d, %s: expected %0d, got %0d",
                 $realtime, results_seen, what, want_v, got_v);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive
        stim_t                nxt;
        logic                 v_s;
        logic                 v_c;
        logic [7:0]           d;
        logic                 f;
        logic [CFG_IDX_W-1:0] ci;
        logic [15:0]          cd;
        int                   settle;
        v_s = s_tvalid; d = s_tdata; f = s_tuser;
        v_c = cfg_valid; ci = cfg_index; cd = cfg_data;
        if (!aresetn) begin
            v_s = 1'b0;
            v_c = 1'b0;
            settle = 0;
        end else begin
            if (s_took) v_s = 1'b0;
            if (cfg_took) v_c = 1'b0;
            if (!v_s && !v_c && pending.size() > 0) begin
                nxt = pending[0];
                case (nxt.act)
                    ACT_BYTE: begin
                        if ($urandom_range(99) >= idle_percent(1'b1)) begin
                            void'(pending.pop_front());
                            v_s = 1'b1; d = nxt.data; f = nxt.first;
                            bytes_sent++;
                        end
                    end
                    ACT_DRAIN: begin
                        // hold off until every result is back, then let the block settle
                        if (expected_q.size() == 0 && !s_took) begin
                            if (settle >= SETTLE_CYCLES) begin
                                void'(pending.pop_front());
                                settle = 0;
                            end else begin
                                settle++;
                            end
                        end else begin
                            settle = 0;
                        end
                    end
                    default: begin
                        void'(pending.pop_front());
                        v_c = 1'b1; ci = nxt.idx; cd = nxt.value;
                    end
                endcase
            end
        end
        s_tvalid  <= v_s;
        s_tdata   <= d;
        s_tuser   <= f;
        cfg_valid <= v_c;
        cfg_index <= ci;
        cfg_data  <= cd;
        m_tready  <= aresetn && ($urandom_range(99) >= idle_percent(1'b0));
    end

    // ------------------------------------------------------------------
    // Monitor: handshakes sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        framer_result_t want;
        framer_result_t got;
        s_took   = aresetn && s_tvalid && s_tready;
        cfg_took = aresetn && cfg_valid && cfg_ready;

        if (aresetn && m_tvalid && m_tready) begin
            got.verdict      = m_tdata[2:0];
            got.path         = m_tdata[3];
            got.index_wanted = m_tdata[4];
            got.line_count   = m_tdata[12:5];
            got.line_done    = m_tlast;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result item", -1, int'(got.verdict));
            end else begin
                want = expected_q.pop_front();
                if (got.verdict != want.verdict)
                    report_mismatch("verdict", want.verdict, got.verdict);
                if (got.path != want.path)
                    report_mismatch("is_path_byte", want.path, got.path);
                if (got.index_wanted != want.index_wanted)
                    report_mismatch("wants_index", want.index_wanted, got.index_wanted);
                if (got.line_done != want.line_done)
                    report_mismatch("line_complete", want.line_done, got.line_done);
                if (got.line_count != want.line_count)
                    report_mismatch("line_index", want.line_count, got.line_count);
                if (want.verdict <= VERDICT_BAD_VERSION) verdict_count[want.verdict]++;
            end
            results_seen++;
        end

        if (cfg_took) begin
            if (cfg_index == REG_LINE_LIMIT) max_lines = cfg_data[7:0];
            else if (cfg_index == REG_BYTE_LIMIT) max_bytes = cfg_data;
            writes_done++;
        end

        if (s_took) begin
            frame_byte(s_tdata, s_tuser, want);
            expected_q.push_back(want);
        end
    end

    // ------------------------------------------------------------------
    // Sequence: stimulus, reset, end of run
    // ------------------------------------------------------------------
    initial begin
        foreach (verdict_count[i]) verdict_count[i] = 0;

        // directed: served index request, an ignored byte, then a new
        // connection with a zero byte, a stray CR and an empty line
        push_text("GET / HTTP/1.1\r\n\r\n", -1);
        pending[0].first = 1'b1;
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_text("\r\r\n\r\n", -1);

        // limit settings, extremes first
        add_setting(16'd255, 16'hFFFF);
        add_traffic(250);
        add_setting(16'd4, 16'd60);
        add_traffic(220);
        add_setting(16'd1, 16'hFFFF);
        add_traffic(80);
        add_setting(16'd255, 16'd1);
        add_traffic(30);
        add_setting(16'd0, 16'd0);
        add_traffic(20);
        add_setting(16'($urandom_range(2, 40)), 16'($urandom_range(20, 300)));
        add_traffic(200);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid || cfg_valid) @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0)
            report_mismatch("results still outstanding", 0, expected_q.size());

        $display("Run covered %0d request bytes, %0d limit writes, %0d result items.",
                 bytes_sent, writes_done, results_seen);
        $display("Verdicts seen: serve %0d, bad request %0d, too large %0d, bad version %0d.",
                 verdict_count[VERDICT_SERVE], verdict_count[VERDICT_BAD_REQUEST],
                 verdict_count[VERDICT_TOO_LARGE], verdict_count[VERDICT_BAD_VERSION]);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
